@@ src/mcu_port_bus_bridge_assert.svh @@
// Assertion macros used by the bridge controller.
`ifndef MCU_PORT_BUS_BRIDGE_ASSERT_SVH
`define MCU_PORT_BUS_BRIDGE_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked at every rising edge outside of reset.
`define MPB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define MPB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MPB_ASSERT(label, clk, rst, prop, msg)
`define MPB_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ src/mpb_pkg.sv @@
package mpb_pkg;

  // Item operation codes.
  typedef enum logic [2:0] {
    OP_PORT1_WR = 3'd0,
    OP_PORT2_WR = 3'd1,
    OP_PORT3_WR = 3'd2,
    OP_PORT4_WR = 3'd3,
    OP_MAIN_RD  = 3'd4,
    OP_MAIN_WR  = 3'd5
  } op_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_B = 2'd1;

  localparam logic [7:0] DIP_A_RESET = 8'hfe;
  localparam logic [7:0] DIP_B_RESET = 8'hff;

  // Port bit positions.
  localparam int P1_IRQ_BIT   = 6;
  localparam int P1_READ_BIT  = 7;
  localparam int P2_START_BIT = 4;

  // Offsets into shared RAM are 10 bits wide.
  localparam int OFFSET_W = 10;

  // Bus select codes for non-RAM reads.
  localparam logic [1:0] SEL_DIP_A = 2'd0;
  localparam logic [1:0] SEL_DIP_B = 2'd1;
  localparam logic [1:0] SEL_JOY_1 = 2'd2;
  localparam logic [1:0] SEL_JOY_2 = 2'd3;

  // What the pending RAM read is used for.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_IRQ,
    RD_BUS,
    RD_MAIN
  } rd_kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_t;

  typedef struct packed {
    logic accept;
    logic finish;
    logic clear_we;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
  } dp_status_t;

endpackage

@@ src/mpb_ram.sv @@
module mpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/mpb_datapath.sv @@
module mpb_datapath import mpb_pkg::*; #(
  parameter int SHARED_WORDS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [2:0]           op,
  input  logic [7:0]           data,
  input  logic [9:0]           main_addr,
  input  logic [7:0]           joy_one,
  input  logic [7:0]           joy_two,
  output logic [7:0]           port3_read,
  output logic [7:0]           main_data,
  output logic                 irq_raise,
  output logic [7:0]           irq_vector
);

  localparam int AW = $clog2(SHARED_WORDS);
  localparam int RW = 13;

  logic [7:0] dip_bank_a;
  logic [7:0] dip_bank_b;
  logic [7:0] port1_latch;
  logic [7:0] port2_latch;
  logic [7:0] port3_out_latch;
  logic [7:0] port4_latch;
  logic [7:0] port3_in_latch;
  rd_kind_t   rd_kind;
  rd_kind_t   rd_kind_next;
  logic [AW-1:0] clear_cnt;

  logic [11:0]         bus_addr;
  logic                bus_start;
  logic                bus_upper;
  logic                load_now;
  logic [7:0]          load_value;
  logic [OFFSET_W-1:0] offset;
  logic [RW-1:0]       reduced;
  logic [AW-1:0]       ram_idx;
  logic                item_we;
  logic [7:0]          item_wdata;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;

  assign bus_addr  = {data[3:0], port4_latch};
  assign bus_upper = (bus_addr[11:10] == 2'b11);
  assign bus_start = !port2_latch[P2_START_BIT] && data[P2_START_BIT];

  // Decode the item: pending RAM read, RAM write and immediate port-3 load.
  always_comb begin
    rd_kind_next = RD_NONE;
    offset       = '0;
    item_we      = 1'b0;
    item_wdata   = port3_out_latch;
    load_now     = 1'b0;
    case (op_t'(op))
      OP_PORT1_WR: begin
        if (port1_latch[P1_IRQ_BIT] && !data[P1_IRQ_BIT]) begin
          rd_kind_next = RD_IRQ;
        end
      end
      OP_PORT2_WR: begin
        offset = bus_addr[OFFSET_W-1:0];
        if (bus_start) begin
          if (port1_latch[P1_READ_BIT]) begin
            if (!bus_addr[11]) begin
              load_now = 1'b1;
            end else if (bus_upper) begin
              rd_kind_next = RD_BUS;
            end
          end else if (bus_upper) begin
            item_we = 1'b1;
          end
        end
      end
      OP_MAIN_RD: begin
        offset       = main_addr;
        rd_kind_next = RD_MAIN;
      end
      OP_MAIN_WR: begin
        offset     = main_addr;
        item_we    = 1'b1;
        item_wdata = data;
      end
      default: begin
      end
    endcase
  end

  // Bus select for DIP banks and joysticks.
  always_comb begin
    case (bus_addr[1:0])
      SEL_DIP_A: load_value = dip_bank_a;
      SEL_DIP_B: load_value = dip_bank_b;
      SEL_JOY_1: load_value = joy_one;
      SEL_JOY_2: load_value = joy_two;
      default:   load_value = joy_two;
    endcase
  end

  // Wrap the offset into the RAM; it is below four times the depth.
  always_comb begin
    reduced = {{(RW - OFFSET_W){1'b0}}, offset};
    for (int k = 0; k < 3; k++) begin
      if (reduced >= RW'(SHARED_WORDS)) begin
        reduced = reduced - RW'(SHARED_WORDS);
      end
    end
    ram_idx = reduced[AW-1:0];
  end

  // The clearing pass owns the write port after reset.
  always_comb begin
    if (cmd.clear_we) begin
      ram_we    = 1'b1;
      ram_waddr = clear_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.accept && item_we;
      ram_waddr = ram_idx;
      ram_wdata = item_wdata;
    end
  end

  assign status.clear_done = (clear_cnt == AW'(SHARED_WORDS - 1));

  mpb_ram #(
    .WIDTH(8),
    .DEPTH(SHARED_WORDS)
  ) u_shared_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.accept),
    .raddr(ram_idx),
    .rdata(ram_rdata)
  );

  // Clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clear_we) begin
      clear_cnt <= clear_cnt + 1'b1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dip_bank_a <= DIP_A_RESET;
      dip_bank_b <= DIP_B_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DIP_A) begin
        dip_bank_a <= cfg_data;
      end
      if (cfg_index == CFG_DIP_B) begin
        dip_bank_b <= cfg_data;
      end
    end
  end

  // Port latches and the port-3 input latch.
  always_ff @(posedge clk) begin
    if (rst) begin
      port1_latch     <= '0;
      port2_latch     <= '0;
      port3_out_latch <= '0;
      port4_latch     <= '0;
      port3_in_latch  <= '0;
      rd_kind         <= RD_NONE;
    end else begin
      if (cmd.accept) begin
        rd_kind <= rd_kind_next;
        case (op_t'(op))
          OP_PORT1_WR: port1_latch     <= data;
          OP_PORT2_WR: port2_latch     <= data;
          OP_PORT3_WR: port3_out_latch <= data;
          OP_PORT4_WR: port4_latch     <= data;
          default: begin
          end
        endcase
        if (load_now) begin
          port3_in_latch <= load_value;
        end
      end
      if (cmd.finish && rd_kind == RD_BUS) begin
        port3_in_latch <= ram_rdata;
      end
    end
  end

  // Result register, loaded when the item finishes.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      port3_read <= (rd_kind == RD_BUS)  ? ram_rdata : port3_in_latch;
      main_data  <= (rd_kind == RD_MAIN) ? ram_rdata : 8'h00;
      irq_raise  <= (rd_kind == RD_IRQ);
      irq_vector <= (rd_kind == RD_IRQ)  ? ram_rdata : 8'h00;
    end
  end

endmodule

@@ src/mpb_ctrl.sv @@
`include "mcu_port_bus_bridge_assert.svh"

module mpb_ctrl import mpb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.finish   = 1'b0;
    cmd.clear_we = 1'b0;
    in_stall     = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // A result stays valid until its transfer.
  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  `MPB_ASSERT(a_accept_then_access, clk, rst, (in_valid && !in_stall) |=> (state == ST_ACCESS), "accepted item did not reach the access state")
  `MPB_ASSERT(a_no_overwrite, clk, rst, !(cmd.finish && out_valid && out_stall), "result register overwritten while stalled")
  `MPB_ASSERT(a_valid_drop, clk, rst, $fell(out_valid) |-> $past(!out_stall), "result dropped without a transfer")
  `MPB_ASSERT(a_clear_complete, clk, rst, ($past(state == ST_CLEAR) && state == ST_IDLE) |-> $past(status.clear_done), "clearing pass left early")

endmodule

@@ src/mcu_port_bus_bridge.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_stall  | op, data, main_addr, joy_one, joy_two
// output   | out_valid / out_stall| port3_read, main_data, irq_raise, irq_vector
// config   | cfg_we               | cfg_index, cfg_data
//
// Each item is transferred in and issues its RAM access in the idle state,
// then finishes in the access state after the registered read of the shared RAM,
// so a new item is taken in only once the last one has finished.
// A result waits in the output register while the next item is taken in.
// After reset a clearing pass zeroes the shared RAM; no item is taken during it,
// configuration writes are. A stall on the output holds the result; the next
// item then waits to finish and no further item is taken in until the stall clears.
module mcu_port_bus_bridge import mpb_pkg::*; #(
  parameter int SHARED_WORDS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           op,
  input  logic [7:0]           data,
  input  logic [9:0]           main_addr,
  input  logic [7:0]           joy_one,
  input  logic [7:0]           joy_two,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           port3_read,
  output logic [7:0]           main_data,
  output logic                 irq_raise,
  output logic [7:0]           irq_vector
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .status   (status)
  );

  mpb_datapath #(
    .SHARED_WORDS(SHARED_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .data      (data),
    .main_addr (main_addr),
    .joy_one   (joy_one),
    .joy_two   (joy_two),
    .port3_read(port3_read),
    .main_data (main_data),
    .irq_raise (irq_raise),
    .irq_vector(irq_vector)
  );

endmodule

@@ tb/tb_mcu_port_bus_bridge.sv @@
module tb_mcu_port_bus_bridge;
  import mpb_pkg::*;

  localparam int SHARED_WORDS = 1024;
  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASES = 5;
  localparam int MAX_IDLE = 14;
  localparam int SETTLE_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT = 10;

  // Op codes that the package leaves unnamed; the bridge must ignore them.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Register indexes past the last register; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // Joystick bytes used throughout the directed rows.
  localparam logic [7:0] JOY1_FIXED = 8'h5a;
  localparam logic [7:0] JOY2_FIXED = 8'h3c;

  typedef struct packed {
    logic [7:0] port3_read;
    logic [7:0] main_data;
    logic       irq_raise;
    logic [7:0] irq_vector;
  } bridge_result_t;

  typedef struct packed {
    logic [2:0]     code;
    logic [7:0]     wdata;
    logic [9:0]     addr;
    logic           fixed;
    bridge_result_t res;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           op = '0;
  logic [7:0]           data = '0;
  logic [9:0]           main_addr = '0;
  logic [7:0]           joy_one = '0;
  logic [7:0]           joy_two = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           port3_read;
  logic [7:0]           main_data;
  logic                 irq_raise;
  logic [7:0]           irq_vector;

  // Shadow copy of the bridge state.
  logic [7:0] dip_a_reg;
  logic [7:0] dip_b_reg;
  logic [7:0] mcu_p1;
  logic [7:0] mcu_p2;
  logic [7:0] mcu_p3_out;
  logic [7:0] mcu_p4;
  logic [7:0] mcu_p3_in;
  logic [7:0] ram_image [SHARED_WORDS];

  bridge_result_t expected_results[$];
  directed_row_t  directed_rows[$];

  int  items_sent = 0;
  int  results_checked = 0;
  int  mismatch_count = 0;
  int  bus_cycles = 0;
  int  irq_count = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  in_burst = 1'b0;
  bit  out_burst = 1'b0;

  always #5 clk = ~clk;

  mcu_port_bus_bridge #(
    .SHARED_WORDS(SHARED_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .data(data),
    .main_addr(main_addr),
    .joy_one(joy_one),
    .joy_two(joy_two),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .port3_read(port3_read),
    .main_data(main_data),
    .irq_raise(irq_raise),
    .irq_vector(irq_vector)
  );

  // Applies one item to the shadow state and returns the result it should produce.
  function automatic bridge_result_t bridge_step(logic [2:0] code, logic [7:0] wdata,
                                                 logic [9:0] addr, logic [7:0] j1,
                                                 logic [7:0] j2);
    bridge_result_t r;
    logic [11:0]    bus_addr;
    r = '0;
    case (code)
      OP_PORT1_WR: begin
        // A falling interrupt bit hands RAM byte zero to the main CPU.
        if (mcu_p1[P1_IRQ_BIT] && !wdata[P1_IRQ_BIT]) begin
          r.irq_raise = 1'b1;
          r.irq_vector = ram_image[0];
          irq_count++;
        end
        mcu_p1 = wdata;
      end
      OP_PORT2_WR: begin
        // A rising start bit runs one bus cycle.
        if (!mcu_p2[P2_START_BIT] && wdata[P2_START_BIT]) begin
          bus_cycles++;
          bus_addr = {wdata[3:0], mcu_p4};
          if (mcu_p1[P1_READ_BIT]) begin
            if (!bus_addr[11]) begin
              case (bus_addr[1:0])
                SEL_DIP_A: mcu_p3_in = dip_a_reg;
                SEL_DIP_B: mcu_p3_in = dip_b_reg;
                SEL_JOY_1: mcu_p3_in = j1;
                default:   mcu_p3_in = j2;
              endcase
            end else if (bus_addr[10]) begin
              mcu_p3_in = ram_image[bus_addr[9:0]];
            end
          end else if (bus_addr[11:10] == 2'b11) begin
            ram_image[bus_addr[9:0]] = mcu_p3_out;
          end
        end
        mcu_p2 = wdata;
      end
      OP_PORT3_WR: mcu_p3_out = wdata;
      OP_PORT4_WR: mcu_p4 = wdata;
      OP_MAIN_RD:  r.main_data = ram_image[addr];
      OP_MAIN_WR:  ram_image[addr] = wdata;
      default: ;
    endcase
    r.port3_read = mcu_p3_in;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] code, logic [7:0] wdata, logic [9:0] addr,
                                  logic fixed, logic [7:0] p3, logic [7:0] md,
                                  logic irq, logic [7:0] vec);
    directed_row_t row;
    row.code = code;
    row.wdata = wdata;
    row.addr = addr;
    row.fixed = fixed;
    row.res = '{port3_read: p3, main_data: md, irq_raise: irq, irq_vector: vec};
    directed_rows.push_back(row);
  endfunction

  // Half of the offsets are taken from a small window so that reads find earlier writes.
  function automatic logic [9:0] pick_offset();
    if ($urandom_range(0, 1) == 1) begin
      return 10'($urandom_range(0, 15));
    end
    return 10'($urandom_range(0, SHARED_WORDS - 1));
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  // Sends one transfer after a random gap (none in a burst) and records what it must produce.
  task automatic send_item(input logic [2:0] code, input logic [7:0] wdata,
                           input logic [9:0] addr, input logic [7:0] j1, input logic [7:0] j2,
                           input logic fixed, input bridge_result_t fixed_res);
    int             gap;
    bridge_result_t predicted;
    gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    data <= wdata;
    main_addr <= addr;
    joy_one <= j1;
    joy_two <= j2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = bridge_step(code, wdata, addr, j1, j2);
    expected_results.push_back(fixed ? fixed_res : predicted);
    items_sent++;
  endtask

  task automatic send_rand(input logic [2:0] code, input logic [7:0] wdata,
                           input logic [9:0] addr);
    send_item(code, wdata, addr, 8'($urandom), 8'($urandom), 1'b0, '0);
  endtask

  // Drives one register write; the caller drops the write enable afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CFG_DIP_A) begin
      dip_a_reg = value;
    end else if (idx == CFG_DIP_B) begin
      dip_b_reg = value;
    end
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic, half of it complete bus cycles and interrupt sequences.
  task automatic run_random(input int count);
    int         stop;
    int         scenario;
    logic [9:0] off;
    logic [3:0] nib;
    logic [7:0] d;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 59) == 0) begin
        in_burst = !in_burst;
      end
      scenario = $urandom_range(0, 9);
      off = pick_offset();
      case (scenario)
        0, 1, 2, 3: begin
          // Full bus cycle: maybe data and mode, low address, then a clean start edge.
          if ($urandom_range(0, 1) == 1) begin
            send_rand(OP_PORT3_WR, 8'($urandom), 10'($urandom));
          end
          if ($urandom_range(0, 2) != 0) begin
            send_rand(OP_PORT1_WR, 8'($urandom), 10'($urandom));
          end
          send_rand(OP_PORT4_WR, off[7:0], 10'($urandom));
          d = 8'($urandom);
          d[P2_START_BIT] = 1'b0;
          send_rand(OP_PORT2_WR, d, 10'($urandom));
          case ($urandom_range(0, 3))
            0, 1:    nib = {2'b11, off[9:8]};
            2:       nib = {1'b0, 3'($urandom)};
            default: nib = 4'($urandom);
          endcase
          d = {3'($urandom), 1'b1, nib};
          send_rand(OP_PORT2_WR, d, 10'($urandom));
        end
        4: begin
          // Interrupt: set the bit, maybe change the vector, then drop the bit.
          d = 8'($urandom);
          d[P1_IRQ_BIT] = 1'b1;
          send_rand(OP_PORT1_WR, d, 10'($urandom));
          if ($urandom_range(0, 1) == 1) begin
            send_rand(OP_MAIN_WR, 8'($urandom), 10'd0);
          end
          d = 8'($urandom);
          d[P1_IRQ_BIT] = 1'b0;
          send_rand(OP_PORT1_WR, d, 10'($urandom));
        end
        5, 6: send_rand(OP_MAIN_WR, 8'($urandom), off);
        7:    send_rand(3'($urandom), 8'($urandom), 10'($urandom));
        8:    send_rand(OP_PORT2_WR, 8'($urandom), 10'($urandom));
        default: send_rand(OP_MAIN_RD, 8'($urandom), off);
      endcase
    end
  endtask

  // Receiver: checks each result transfer and, outside a burst, stalls for a random count after it, which may be zero.
  always @(posedge clk) begin : result_check
    bridge_result_t want;
    int             hold;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result transfer", 0, port3_read);
        end else begin
          want = expected_results.pop_front();
          if (port3_read !== want.port3_read) begin
            note_mismatch("port3_read", want.port3_read, port3_read);
          end
          if (main_data !== want.main_data) begin
            note_mismatch("main_data", want.main_data, main_data);
          end
          if (irq_raise !== want.irq_raise) begin
            note_mismatch("irq_raise", want.irq_raise, irq_raise);
          end
          if (irq_vector !== want.irq_vector) begin
            note_mismatch("irq_vector", want.irq_vector, irq_vector);
          end
        end
        if ($urandom_range(0, 59) == 0) begin
          out_burst = !out_burst;
        end
        hold = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
        stall_left <= hold;
        out_stall <= (hold != 0);
      end else if (out_stall) begin
        if (stall_left <= 1) begin
          out_stall <= 1'b0;
        end
        stall_left <= stall_left - 1;
      end
    end
  end

  // Ends a run in which no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Shadow state starts from its reset values.
    dip_a_reg = DIP_A_RESET;
    dip_b_reg = DIP_B_RESET;
    mcu_p1 = '0;
    mcu_p2 = '0;
    mcu_p3_out = '0;
    mcu_p4 = '0;
    mcu_p3_in = '0;
    for (int i = 0; i < SHARED_WORDS; i++) begin
      ram_image[i] = '0;
    end

    // Directed rows: RAM extremes, each DIP and joystick select, the dead
    // address region, a bus write, an interrupt and both unused op codes.
    add_row(OP_MAIN_RD,  8'h00, 10'h000, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_MAIN_WR,  8'ha5, 10'h000, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_MAIN_WR,  8'hff, 10'h3ff, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_MAIN_RD,  8'h00, 10'h3ff, 1'b1, 8'h00, 8'hff, 1'b0, 8'h00);
    add_row(OP_PORT1_WR, 8'hc0, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT4_WR, 8'h00, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h10, 10'h000, 1'b1, 8'hfe, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT4_WR, 8'h01, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h00, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h10, 10'h000, 1'b1, 8'hff, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT4_WR, 8'h02, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h00, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h10, 10'h000, 1'b1, JOY1_FIXED, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT4_WR, 8'hff, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h00, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h17, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h00, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h1f, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h00, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h1b, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT3_WR, 8'h81, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT1_WR, 8'h40, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT4_WR, 8'h00, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h00, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT2_WR, 8'h1c, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_PORT1_WR, 8'h00, 10'h000, 1'b1, 8'hff, 8'h00, 1'b1, 8'h81);
    add_row(OP_MAIN_RD,  8'h00, 10'h000, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
    add_row(OP_SPARE_6,  8'hff, 10'h3ff, 1'b1, 8'hff, 8'h00, 1'b0, 8'h00);
    add_row(OP_SPARE_7,  8'hff, 10'h3ff, 1'b1, 8'hff, 8'h00, 1'b0, 8'h00);

    // Hold reset, then release it once.
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].code, directed_rows[i].wdata, directed_rows[i].addr,
                JOY1_FIXED, JOY2_FIXED, directed_rows[i].fixed, directed_rows[i].res);
    end
    in_valid <= 1'b0;

    // Random phases, each under its own DIP setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_reg(CFG_DIP_A, 8'h00);
          write_reg(CFG_DIP_B, 8'hff);
        end
        1: begin
          write_reg(CFG_DIP_A, 8'hff);
          write_reg(CFG_DIP_B, 8'h00);
        end
        2: begin
          write_reg(CFG_DIP_A, 8'($urandom));
          write_reg(CFG_DIP_B, 8'($urandom));
          write_reg(CFG_SPARE_2, 8'($urandom));
          write_reg(CFG_SPARE_3, 8'($urandom));
        end
        3: begin
          write_reg(CFG_DIP_A, 8'h00);
          write_reg(CFG_DIP_B, 8'h00);
        end
        default: begin
          write_reg(CFG_DIP_A, 8'hff);
          write_reg(CFG_DIP_B, 8'hff);
        end
      endcase
      cfg_we <= 1'b0;
      run_random(RANDOM_ITEMS / PHASES);
      in_valid <= 1'b0;
    end

    // Drain the last results, then report.
    wait_drained();
    if (expected_results.size() != 0) begin
      note_mismatch("results still outstanding", 0, expected_results.size());
    end
    $display("Run covered %0d items and %0d checked results under %0d DIP settings.",
             items_sent, results_checked, PHASES + 1);
    $display("Bus cycles started: %0d, interrupts raised: %0d, mismatches: %0d.",
             bus_cycles, irq_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
